// ===== design/sff_pkg.sv =====
package sff_pkg;

  localparam int SRC_W     = 15;
  localparam int SENDER_W  = 16;
  localparam int SESS_IN_W = 32;
  localparam int SEQ_IN_W  = 32;
  localparam int TIME_W    = 64;
  localparam int TMO_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TMO_W-1:0] STALE_TIMEOUT_RST = 32'd10000;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT   = 2'd1;

  typedef enum logic [0:0] {
    MODE_ACCEPT = 1'b0,
    MODE_POLL   = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_INVALID      = 3'd1,
    ST_SOURCE_UNSET = 3'd2,
    ST_OTHER_SOURCE = 3'd3,
    ST_OLD          = 3'd4
  } status_t;

  typedef struct packed {
    mode_t                 mode;
    logic [SENDER_W-1:0]   sender_id;
    logic                  decode_ok;
    logic [SESS_IN_W-1:0]  session_tag;
    logic [SEQ_IN_W-1:0]   sequence_num;
    logic [TIME_W-1:0]     now_ms;
  } item_t;

  typedef struct packed {
    logic    went_stale;
    status_t status;
  } result_t;

  typedef struct packed {
    logic [SRC_W-1:0] expected_source;
    logic [TMO_W-1:0] stale_timeout_ms;
    logic             clear;
  } cfg_t;

endpackage

// ===== design/sff_cfg.sv =====
module sff_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sff_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sff_pkg::CFG_DATA_W-1:0]    cfg_data,
  output sff_pkg::cfg_t                     cfg
);
  import sff_pkg::*;

  logic [SRC_W-1:0] expected_source_r, expected_source_nxt;
  logic [TMO_W-1:0] stale_timeout_r, stale_timeout_nxt;
  logic             wr;
  logic [SRC_W-1:0] src_val;
  logic [TMO_W-1:0] tmo_val;
  logic             clear;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign src_val   = cfg_data[SRC_W-1:0];
  assign tmo_val   = cfg_data[TMO_W-1:0];

  // zero writes are dropped; a new source also wipes the filter state
  always_comb begin
    expected_source_nxt = expected_source_r;
    stale_timeout_nxt   = stale_timeout_r;
    clear               = 1'b0;
    if (wr) begin
      if (cfg_index == REG_EXPECTED_SOURCE && src_val != '0) begin
        expected_source_nxt = src_val;
        clear               = 1'b1;
      end else if (cfg_index == REG_STALE_TIMEOUT && tmo_val != '0) begin
        stale_timeout_nxt = tmo_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_source_r <= '0;
      stale_timeout_r   <= STALE_TIMEOUT_RST;
    end else begin
      expected_source_r <= expected_source_nxt;
      stale_timeout_r   <= stale_timeout_nxt;
    end
  end

  assign cfg.expected_source  = expected_source_r;
  assign cfg.stale_timeout_ms = stale_timeout_r;
  assign cfg.clear            = clear;

endmodule

// ===== design/sff_core.sv =====
module sff_core #(
  parameter int SESSION_WIDTH  = 32,
  parameter int SEQUENCE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  sff_pkg::item_t   item,
  input  sff_pkg::cfg_t    cfg,
  output sff_pkg::result_t result
);
  import sff_pkg::*;

  localparam int SESS_W = (SESSION_WIDTH < SESS_IN_W) ? SESSION_WIDTH : SESS_IN_W;
  localparam int SEQ_W  = (SEQUENCE_WIDTH < SEQ_IN_W) ? SEQUENCE_WIDTH : SEQ_IN_W;

  logic              have_sample_r, have_sample_nxt;
  logic              stale_mark_r, stale_mark_nxt;
  logic [SESS_W-1:0] last_session_r, last_session_nxt;
  logic [SEQ_W-1:0]  last_sequence_r, last_sequence_nxt;
  logic [SESS_W-1:0] prior_session_r, prior_session_nxt;
  logic [TIME_W-1:0] accept_time_r, accept_time_nxt;

  logic [SESS_W-1:0] sess;
  logic [SEQ_W-1:0]  seq;
  logic              time_back;
  logic              is_old;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;

  assign sess      = item.session_tag[SESS_W-1:0];
  assign seq       = item.sequence_num[SEQ_W-1:0];
  assign time_back = item.now_ms < accept_time_r;
  assign is_old    = (sess == prior_session_r) ||
                     (sess == last_session_r && seq <= last_sequence_r);
  assign elapsed   = item.now_ms - accept_time_r;
  assign timed_out = elapsed >= {{(TIME_W-TMO_W){1'b0}}, cfg.stale_timeout_ms};

  always_comb begin
    have_sample_nxt   = have_sample_r;
    stale_mark_nxt    = stale_mark_r;
    last_session_nxt  = last_session_r;
    last_sequence_nxt = last_sequence_r;
    prior_session_nxt = prior_session_r;
    accept_time_nxt   = accept_time_r;
    result.status     = ST_ACCEPTED;
    result.went_stale = 1'b0;

    unique case (item.mode)
      MODE_ACCEPT: begin
        priority if (cfg.expected_source == '0) begin
          result.status = ST_SOURCE_UNSET;
        end else if (item.sender_id != {1'b0, cfg.expected_source}) begin
          result.status = ST_OTHER_SOURCE;
        end else if (!item.decode_ok) begin
          result.status = ST_INVALID;
        end else if (have_sample_r && time_back) begin
          result.status = ST_INVALID;
        end else if (have_sample_r && is_old) begin
          result.status = ST_OLD;
        end else begin
          if (have_sample_r && sess != last_session_r) begin
            prior_session_nxt = last_session_r;
          end
          last_session_nxt  = sess;
          last_sequence_nxt = seq;
          accept_time_nxt   = item.now_ms;
          have_sample_nxt   = 1'b1;
          stale_mark_nxt    = 1'b0;
        end
      end
      MODE_POLL: begin
        // flag once per quiet period, never when time runs backwards
        if (have_sample_r && !stale_mark_r && !time_back && timed_out) begin
          stale_mark_nxt    = 1'b1;
          result.went_stale = 1'b1;
        end
      end
      default: begin
        result.status = ST_ACCEPTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      have_sample_r   <= 1'b0;
      stale_mark_r    <= 1'b0;
      last_session_r  <= '0;
      last_sequence_r <= '0;
      prior_session_r <= '0;
      accept_time_r   <= '0;
    end else if (fire) begin
      have_sample_r   <= have_sample_nxt;
      stale_mark_r    <= stale_mark_nxt;
      last_session_r  <= last_session_nxt;
      last_sequence_r <= last_sequence_nxt;
      prior_session_r <= prior_session_nxt;
      accept_time_r   <= accept_time_nxt;
    end
  end

endmodule

// ===== design/sample_freshness_filter.sv =====
// Sample freshness filter for decoded position packets.
// Input stream (in_*): one transaction per packet check (in_tuser = 0) or
// staleness poll (in_tuser = 1). Output stream (out_*): one transaction per
// input, carrying the status code and the went-stale flag.
// Config channel (cfg_*): index 0 sets the expected source (nonzero write
// also clears the held sample), index 1 sets the stale timeout in ms. Zero
// writes are dropped. cfg_ready is always high; write only while idle.
// Path: an accepted input passes through the input register, then the result
// register. Throughput: one transaction per cycle while the receiver keeps
// out_tready high; the held sample state is read and updated as an item
// moves from the input register into the result register.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more; in_tready then drops until the
// result is taken.
// Reset (rst_n low, synchronous): both streams empty, no source set,
// timeout 10000 ms, no sample held.
module sample_freshness_filter #(
  parameter int SESSION_WIDTH  = 32,
  parameter int SEQUENCE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // sender_id[15:0], decode_ok[16], session_tag[48:17], sequence_num[80:49],
  // now_ms[144:81], zero pad [151:145]
  input  logic [151:0]                   in_tdata,
  // mode[0]
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[2:0], went_stale[3], zero pad [7:4]
  output logic [7:0]                     out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sff_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sff_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   in_item_r, in_item_nxt;
  logic    in_valid_r, in_valid_nxt;
  result_t core_res;
  result_t out_res_r, out_res_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;

  assign in_item.mode         = mode_t'(in_tuser[0]);
  assign in_item.sender_id    = in_tdata[15:0];
  assign in_item.decode_ok    = in_tdata[16];
  assign in_item.session_tag  = in_tdata[48:17];
  assign in_item.sequence_num = in_tdata[80:49];
  assign in_item.now_ms       = in_tdata[144:81];

  sff_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // item moves into the result register when that slot is free or emptying
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  sff_core #(
    .SESSION_WIDTH  (SESSION_WIDTH),
    .SEQUENCE_WIDTH (SEQUENCE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (core_res)
  );

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_item_nxt   = in_item_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
      in_item_nxt  = in_item;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.went_stale, out_res_r.status};

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after an item advanced");

  a_stale_only_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.went_stale && out_res_r.status != ST_ACCEPTED))
    else $error("went_stale set together with a nonzero status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status <= ST_OLD))
    else $error("status code out of range");

endmodule

// ===== dv/sample_freshness_filter_test.sv =====
module sample_freshness_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sff_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 120;

  class freshness_scoreboard;
    logic [SRC_W-1:0]     source;
    logic [TMO_W-1:0]     timeout;
    bit                   held;
    bit                   stale;
    logic [SESS_IN_W-1:0] last_sess;
    logic [SESS_IN_W-1:0] prior_sess;
    logic [SEQ_IN_W-1:0]  last_seq;
    logic [TIME_W-1:0]    accept_time;
    result_t              pending_verdicts[$];
    int unsigned          errors;
    int unsigned          checked;
    int unsigned          stale_events;
    int unsigned          status_seen[5];

    function new();
      source  = '0;
      timeout = STALE_TIMEOUT_RST;
      errors = 0;
      checked = 0;
      stale_events = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_held();
    endfunction

    function void clear_held();
      held        = 1'b0;
      stale       = 1'b0;
      last_sess   = '0;
      prior_sess  = '0;
      last_seq    = '0;
      accept_time = '0;
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    // zero writes and unknown indexes leave everything alone
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EXPECTED_SOURCE: begin
          if (val[SRC_W-1:0] != '0) begin
            source = val[SRC_W-1:0];
            clear_held();
          end
        end
        REG_STALE_TIMEOUT: begin
          if (val != '0) timeout = val;
        end
        default: ;
      endcase
    endfunction

    function result_t judge_item(item_t it);
      result_t r;
      r.status     = ST_ACCEPTED;
      r.went_stale = 1'b0;
      if (it.mode == MODE_POLL) begin
        if (held && !stale && it.now_ms >= accept_time &&
            (it.now_ms - accept_time) >= {32'b0, timeout}) begin
          stale = 1'b1;
          r.went_stale = 1'b1;
        end
        return r;
      end
      if (source == '0)
        r.status = ST_SOURCE_UNSET;
      else if (it.sender_id != {1'b0, source})
        r.status = ST_OTHER_SOURCE;
      else if (!it.decode_ok)
        r.status = ST_INVALID;
      else if (held && it.now_ms < accept_time)
        r.status = ST_INVALID;
      else if (held && (it.session_tag == prior_sess ||
               (it.session_tag == last_sess && it.sequence_num <= last_seq)))
        r.status = ST_OLD;
      else begin
        if (held && it.session_tag != last_sess) prior_sess = last_sess;
        last_sess   = it.session_tag;
        last_seq    = it.sequence_num;
        accept_time = it.now_ms;
        held        = 1'b1;
        stale       = 1'b0;
      end
      return r;
    endfunction

    function void note_item(item_t it);
      pending_verdicts.push_back(judge_item(it));
    endfunction

    function void check_result(logic [7:0] data);
      result_t want;
      bit bad;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result 0x%02h with nothing expected", $time, data);
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      bad = 1'b0;
      if (data[2:0] != want.status) begin
        bad = 1'b1;
        $display("%0t: status expected %0d actual %0d", $time, want.status, data[2:0]);
      end
      if (data[3] != want.went_stale) begin
        bad = 1'b1;
        $display("%0t: went_stale expected %0b actual %0b", $time, want.went_stale,
                 data[3]);
      end
      if (bad) errors++;
      else begin
        status_seen[int'(want.status)]++;
        stale_events += want.went_stale;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [151:0]          in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  freshness_scoreboard sb;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // steering state for well-formed packet sequences
  logic [SRC_W-1:0]     cur_source;
  logic [TMO_W-1:0]     cur_timeout;
  logic [SESS_IN_W-1:0] gen_sess;
  logic [SESS_IN_W-1:0] gen_prior;
  logic [SEQ_IN_W-1:0]  gen_seq;
  logic [TIME_W-1:0]    gen_time;

  sample_freshness_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic item_t pkt(input logic [SENDER_W-1:0] snd, input logic ok,
                                input logic [SESS_IN_W-1:0] sess,
                                input logic [SEQ_IN_W-1:0] seq,
                                input logic [TIME_W-1:0] now);
    item_t it;
    it.mode         = MODE_ACCEPT;
    it.sender_id    = snd;
    it.decode_ok    = ok;
    it.session_tag  = sess;
    it.sequence_num = seq;
    it.now_ms       = now;
    return it;
  endfunction

  function automatic item_t poll_at(input logic [TIME_W-1:0] now);
    item_t it;
    it = pkt('0, 1'b0, '0, '0, now);
    it.mode = MODE_POLL;
    return it;
  endfunction

  // mostly in-order packets and timed polls, the rest broken or pure noise
  function automatic item_t next_item();
    item_t it;
    logic [159:0] noise;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = pkt({1'b0, cur_source}, 1'b1, gen_sess, gen_seq, gen_time);
    if (pick < 60) begin
      if ($urandom_range(0, 11) == 0) begin
        gen_prior = gen_sess;
        gen_sess  = ($urandom_range(0, 3) == 0) ? gen_sess + 1 : $urandom;
        gen_seq   = $urandom;
      end else begin
        gen_seq += $urandom_range(1, 3);
      end
      gen_time += $urandom_range(0, 40);
      it = pkt({1'b0, cur_source}, 1'b1, gen_sess, gen_seq, gen_time);
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0:       gen_time += cur_timeout - 1;
        1:       gen_time += cur_timeout;
        2:       gen_time += 64'(cur_timeout) + $urandom_range(1, 1000);
        default: gen_time += $urandom_range(0, 20);
      endcase
      it = pkt(16'($urandom), 1'($urandom), $urandom, $urandom, gen_time);
      it.mode = MODE_POLL;
    end else begin
      it.sequence_num = gen_seq + 1;
      case ($urandom_range(0, 6))
        0: it.sender_id = 16'($urandom);
        1: it.decode_ok = 1'b0;
        2: it.now_ms = gen_time - $urandom_range(1, 100);
        3: it.sequence_num = gen_seq - $urandom_range(0, 2);
        4: it.session_tag = gen_prior;
        5: begin
          it.mode   = MODE_POLL;
          it.now_ms = gen_time - $urandom_range(1, 100);
        end
        default: begin
          noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
          it = noise[$bits(item_t)-1:0];
        end
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {7'b0, it.now_ms, it.sequence_num, it.session_tag, it.decode_ok,
                  it.sender_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned kind);
    case (kind)
      0:       begin gap_pct = 20; stall_pct = 59; end
      1:       begin gap_pct = 59; stall_pct = 20; end
      default: begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  initial begin
    logic [SRC_W-1:0] src;
    logic [TMO_W-1:0] tmo;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    set_idling(0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing configured yet
    send_item(pkt(16'd5, 1'b1, 32'd1, 32'd1, 64'd100));
    send_item(poll_at(64'd20000));
    settle();
    write_reg(REG_EXPECTED_SOURCE, 32'h0);
    write_reg(REG_EXPECTED_SOURCE, 32'h8000);
    write_reg(REG_STALE_TIMEOUT, 32'h0);
    write_reg(REG_SPARE_2, 32'h1234);
    write_reg(REG_SPARE_3, 32'hffff_ffff);
    write_reg(REG_EXPECTED_SOURCE, 32'd5);

    send_item(pkt(16'hffff, 1'b1, 32'd7, 32'd10, 64'd1000));
    send_item(pkt(16'd5, 1'b0, 32'd7, 32'd10, 64'd1000));
    send_item(pkt(16'd5, 1'b1, 32'd7, 32'd10, 64'd1000));
    // session 0 matches the initial prior session
    send_item(pkt(16'd5, 1'b1, 32'd0, 32'd50, 64'd1500));
    send_item(pkt(16'd5, 1'b1, 32'd7, 32'd11, 64'd999));
    send_item(pkt(16'd5, 1'b1, 32'd7, 32'd10, 64'd1000));
    send_item(pkt(16'd5, 1'b1, 32'd7, 32'd11, 64'd1000));
    send_item(poll_at(64'd10999));
    send_item(poll_at(64'd11000));
    send_item(poll_at(64'd12000));
    send_item(pkt(16'd5, 1'b1, 32'd9, 32'd0, 64'd11000));
    send_item(pkt(16'd5, 1'b1, 32'd7, 32'd100, 64'd11001));
    send_item(poll_at(64'd500));
    send_item(pkt(16'd5, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_fff0));
    send_item(poll_at(64'hffff_ffff_ffff_ffff));
    send_item(pkt(16'd5, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff));
    settle();
    // timeout change keeps the held sample
    write_reg(REG_STALE_TIMEOUT, 32'd1);
    send_item(poll_at(64'hffff_ffff_ffff_ffff));
    settle();
    write_reg(REG_EXPECTED_SOURCE, 32'd5);
    send_item(pkt(16'd5, 1'b1, 32'd0, 32'd0, 64'd0));
    send_item(pkt(16'd5, 1'b1, 32'd0, 32'd0, 64'd0));
    send_item(poll_at(64'd0));
    send_item(poll_at(64'd1));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin src = 15'd1; tmo = 32'd1; end
        1: begin src = 15'h7fff; tmo = 32'hffff_ffff; end
        2: begin src = 15'($urandom_range(1, 32767)); tmo = $urandom_range(1, 200); end
        3: begin src = 15'($urandom_range(1, 32767)); tmo = STALE_TIMEOUT_RST; end
        4: begin src = 15'($urandom_range(1, 32767)); tmo = $urandom | 32'h1; end
        default: begin src = 15'($urandom_range(1, 32767)); tmo = $urandom_range(20, 5000); end
      endcase
      set_idling(ph / 2);
      settle();
      write_reg(REG_STALE_TIMEOUT, tmo);
      write_reg(REG_EXPECTED_SOURCE, {17'($urandom), src});
      write_reg((ph % 2 == 1) ? REG_SPARE_3 : REG_SPARE_2, $urandom);
      cur_source  = src;
      cur_timeout = tmo;
      gen_sess    = $urandom;
      gen_prior   = '0;
      gen_seq     = $urandom;
      gen_time    = (ph % 2 == 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000));
      repeat (ITEMS_PER_PHASE) send_item(next_item());
    end
    settle();

    $display("checked %0d results: %0d accepted, %0d invalid, %0d no source,",
             sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
    $display("  %0d other source, %0d old; %0d polls raised the stale mark",
             sb.status_seen[3], sb.status_seen[4], sb.stale_events);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sff_pkg.sv
design/sff_cfg.sv
design/sff_core.sv
design/sample_freshness_filter.sv
dv/sample_freshness_filter_test.sv
